// ----- src/incremental_pi_current_loop_assert.svh -----
// Assertion macros for the current loop checker.
`ifndef INCREMENTAL_PI_CURRENT_LOOP_ASSERT_SVH
`define INCREMENTAL_PI_CURRENT_LOOP_ASSERT_SVH

// Same-cycle implication.
`define IPCL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define IPCL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/ipcl_pkg.sv -----
package ipcl_pkg;

   localparam int CurW     = 16;
   localparam int ErrW     = CurW + 1;
   localparam int GainW    = 16;
   localparam int LimW     = 15;
   localparam int DutyW    = 13;
   localparam int FracW    = 8;
   localparam int AccW     = 22;
   localparam int StepW    = 16;
   localparam int ShiftW   = 12;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_KP,
      CSR_KI,
      CSR_MAX_CURRENT,
      CSR_STEP_LIMIT,
      CSR_MIN_DUTY,
      CSR_MAX_DUTY
   } csr_index_type;

   typedef struct packed {
      logic signed [GainW-1:0] kp;
      logic signed [GainW-1:0] ki;
      logic [LimW-1:0]         max_current;
      logic [LimW-1:0]         step_limit;
      logic [DutyW-1:0]        min_duty;
      logic [DutyW-1:0]        max_duty;
   } cfg_type;

   localparam logic [LimW-1:0]  MaxCurrentRst = 15'd32767;
   localparam logic [LimW-1:0]  StepLimitRst  = 15'd2560;
   localparam logic [DutyW-1:0] MinDutyRst    = 13'd10;
   localparam logic [DutyW-1:0] MaxDutyRst    = 13'd4190;

endpackage

// ----- src/ipcl_csr.sv -----
module ipcl_csr
   import ipcl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_KP:          cfg_in.kp          = csr_wdata;
            CSR_KI:          cfg_in.ki          = csr_wdata;
            CSR_MAX_CURRENT: cfg_in.max_current = csr_wdata[LimW-1:0];
            CSR_STEP_LIMIT:  cfg_in.step_limit  = csr_wdata[LimW-1:0];
            CSR_MIN_DUTY:    cfg_in.min_duty    = csr_wdata[DutyW-1:0];
            CSR_MAX_DUTY:    cfg_in.max_duty    = csr_wdata[DutyW-1:0];
            default:         cfg_in = cfg_ff;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp          <= '0;
         cfg_ff.ki          <= '0;
         cfg_ff.max_current <= MaxCurrentRst;
         cfg_ff.step_limit  <= StepLimitRst;
         cfg_ff.min_duty    <= MinDutyRst;
         cfg_ff.max_duty    <= MaxDutyRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/ipcl_pid.sv -----
module ipcl_pid
   import ipcl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [CurW-1:0]  req_measured_current,
   input  logic signed [CurW-1:0]  req_target_current,
   output logic                    step_valid,
   input  logic                    step_take,
   output logic signed [StepW-1:0] step_value
);

   localparam int DiffW  = ErrW + 1;
   localparam int PProdW = GainW + DiffW;
   localparam int IProdW = GainW + ErrW;
   localparam int PW     = PProdW - ShiftW;
   localparam int IW     = IProdW - ShiftW;
   localparam int SumW   = PW + 2;

   // stage A: error
   logic                   a_vld_ff;
   logic signed [ErrW-1:0] a_err_ff, a_err_in;
   logic signed [CurW-1:0] clip_meas;
   logic                   a_load;

   // stage B: products
   logic                   b_vld_ff;
   logic signed [ErrW-1:0] err_last_ff;
   logic signed [DiffW-1:0] err_diff;
   logic signed [PProdW-1:0] p_prod;
   logic signed [IProdW-1:0] i_prod;
   logic signed [PW-1:0]   b_p_ff;
   logic signed [IW-1:0]   b_i_ff;
   logic                   b_load;

   // stage C: step, doubles as previous step
   logic                    c_vld_ff;
   logic signed [StepW-1:0] step_ff, step_in;
   logic signed [SumW-1:0]  step_sum, lim_pos, lim_neg;
   logic                    c_load;

   assign c_load    = !c_vld_ff || step_take;
   assign b_load    = !b_vld_ff || c_load;
   assign a_load    = !a_vld_ff || b_load;
   assign req_stall = !a_load;

   always_comb begin
      clip_meas = req_measured_current;
      if (req_measured_current > $signed({1'b0, cfg.max_current}))
         clip_meas = $signed({1'b0, cfg.max_current});
      a_err_in = ErrW'(req_target_current) - ErrW'(clip_meas);
   end

   assign err_diff = DiffW'(a_err_ff) - DiffW'(err_last_ff);
   assign p_prod   = PProdW'(cfg.kp) * PProdW'(err_diff);
   assign i_prod   = IProdW'(cfg.ki) * IProdW'(a_err_ff);

   // step_prev + p + i, then symmetric saturation
   always_comb begin
      lim_pos  = $signed({{(SumW-LimW){1'b0}}, cfg.step_limit});
      lim_neg  = -lim_pos;
      step_sum = SumW'(step_ff) + SumW'(b_p_ff) + SumW'(b_i_ff);
      if (step_sum > lim_pos)
         step_sum = lim_pos;
      if (step_sum < lim_neg)
         step_sum = lim_neg;
      step_in = step_sum[StepW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff    <= 1'b0;
         b_vld_ff    <= 1'b0;
         c_vld_ff    <= 1'b0;
         err_last_ff <= '0;
         step_ff     <= '0;
      end else begin
         if (a_load)
            a_vld_ff <= req_valid;
         if (b_load) begin
            b_vld_ff <= a_vld_ff;
            if (a_vld_ff)
               err_last_ff <= a_err_ff;
         end
         if (c_load) begin
            c_vld_ff <= b_vld_ff;
            if (b_vld_ff)
               step_ff <= step_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_load)
         a_err_ff <= a_err_in;
      if (b_load) begin
         // arithmetic shift floors the Q.20 products to Q.8
         b_p_ff <= p_prod[PProdW-1:ShiftW];
         b_i_ff <= i_prod[IProdW-1:ShiftW];
      end
   end

   assign step_valid = c_vld_ff;
   assign step_value = step_ff;

endmodule

// ----- src/ipcl_duty.sv -----
module ipcl_duty
   import ipcl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    step_valid,
   output logic                    step_take,
   input  logic signed [StepW-1:0] step_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [DutyW-1:0]        rsp_duty,
   output logic signed [StepW-1:0] rsp_step_out
);

   localparam int SumW = AccW + 2;

   logic                    rsp_vld_ff;
   logic [AccW-1:0]         acc_ff, acc_in;
   logic signed [StepW-1:0] step_out_ff;
   logic signed [SumW-1:0]  acc_sum, top, bottom;
   logic                    load;

   assign load      = !rsp_vld_ff || !rsp_stall;
   assign step_take = load;

   // top tested first, so an inverted window resolves to max or min
   always_comb begin
      top     = $signed(SumW'({cfg.max_duty, {FracW{1'b0}}}));
      bottom  = $signed(SumW'({cfg.min_duty, {FracW{1'b0}}}));
      acc_sum = $signed({2'b00, acc_ff}) + SumW'(step_value);
      if (acc_sum > top)
         acc_sum = top;
      else if (acc_sum < bottom)
         acc_sum = bottom;
      acc_in = acc_sum[AccW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         acc_ff     <= '0;
      end else if (load) begin
         rsp_vld_ff <= step_valid;
         if (step_valid)
            acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && step_valid)
         step_out_ff <= step_value;
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_duty     = acc_ff[DutyW+FracW-1:FracW];
   assign rsp_step_out = step_out_ff;

endmodule

// ----- src/incremental_pi_current_loop.sv -----
// Incremental PI current loop with duty accumulator.
//
// req_*: one item per PWM period, measured and target phase current, Q4.12.
//   An item is taken at a clock edge with req_valid high and req_stall low.
// rsp_*: one item per request, integer duty compare value and the saturated
//   step in Q.8 counts. Taken at an edge with rsp_valid high, rsp_stall low.
// csr_*: gain and limit registers, index 0..5 = kp, ki, max_current,
//   step_limit, min_duty, max_duty. csr_ready is always high; write only
//   while no item is in flight.
//
// Four register stages: error, products, step, duty. An item taken on req_*
// passes through these registers in that order to rsp_*. One item per cycle
// sustained while rsp_stall stays low; each state loop (step, accumulator) closes inside its own stage.
// While rsp_stall is high the pipe keeps filling its empty stages; with all
// four full, req_stall rises. Synchronous reset clears the registers to
// their defaults, the error, step and accumulator history to zero, and
// empties the pipe.
module incremental_pi_current_loop
   import ipcl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [CurW-1:0]  req_measured_current,
   input  logic signed [CurW-1:0]  req_target_current,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [DutyW-1:0]        rsp_duty,
   output logic signed [StepW-1:0] rsp_step_out,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIdxW-1:0]      csr_index,
   input  logic [CsrDataW-1:0]     csr_wdata
);

   cfg_type                 cfg;
   logic                    step_valid;
   logic                    step_take;
   logic signed [StepW-1:0] step_value;

   ipcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // error, gain products and saturated step
   ipcl_pid u_pid (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_measured_current (req_measured_current),
      .req_target_current   (req_target_current),
      .step_valid           (step_valid),
      .step_take            (step_take),
      .step_value           (step_value)
   );

   // accumulator clamp and output register
   ipcl_duty u_duty (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .step_valid   (step_valid),
      .step_take    (step_take),
      .step_value   (step_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_duty     (rsp_duty),
      .rsp_step_out (rsp_step_out)
   );

endmodule

// ----- src/ipcl_checker.sv -----
`include "incremental_pi_current_loop_assert.svh"

module ipcl_checker
   import ipcl_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [DutyW-1:0]        rsp_duty,
   input logic signed [StepW-1:0] rsp_step_out,
   input logic                    csr_valid,
   input logic                    csr_ready,
   input logic [CsrIdxW-1:0]      csr_index,
   input logic [CsrDataW-1:0]     csr_wdata
);

   // shadow copies of the step and duty limit registers
   logic [LimW-1:0]  lim_ff;
   logic [DutyW-1:0] min_ff;
   logic [DutyW-1:0] max_ff;
   logic             wr;

   assign wr = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= StepLimitRst;
         min_ff <= MinDutyRst;
         max_ff <= MaxDutyRst;
      end else if (wr) begin
         if (csr_index == CSR_STEP_LIMIT)
            lim_ff <= csr_wdata[LimW-1:0];
         if (csr_index == CSR_MIN_DUTY)
            min_ff <= csr_wdata[DutyW-1:0];
         if (csr_index == CSR_MAX_DUTY)
            max_ff <= csr_wdata[DutyW-1:0];
      end
   end

   `IPCL_ASSERT_IMP(a_step_sat, clock, reset, rsp_valid,
      (rsp_step_out <= $signed({1'b0, lim_ff})) &&
      (rsp_step_out >= -$signed({1'b0, lim_ff})),
      "step outside step limit")

   `IPCL_ASSERT_IMP(a_duty_window, clock, reset, rsp_valid,
      (rsp_duty == max_ff) || (rsp_duty == min_ff) ||
      ((rsp_duty > min_ff) && (rsp_duty < max_ff)),
      "duty outside window")

   `IPCL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_duty) && $stable(rsp_step_out),
      "stalled result changed")

endmodule

bind incremental_pi_current_loop ipcl_checker u_ipcl_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_duty     (rsp_duty),
   .rsp_step_out (rsp_step_out),
   .csr_valid    (csr_valid),
   .csr_ready    (csr_ready),
   .csr_index    (csr_index),
   .csr_wdata    (csr_wdata)
);

// ----- tb/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ipcl_pkg::*;

   // Run shape
   localparam int RandomItems     = 1950;
   localparam int RandomPhases    = 6;
   localparam int LongHoldCycles  = 60;    // receiver hold-off that backs the pipe up
   localparam int TailCycles      = 8;     // pipe is four stages deep
   localparam int StallWatchLimit = 2000;  // cycles without any handshake

   typedef struct packed {
      logic signed [CurW-1:0] meas;
      logic signed [CurW-1:0] target;
   } sample_type;

   typedef struct packed {
      logic [DutyW-1:0]        duty;
      logic signed [StepW-1:0] step;
   } duty_step_type;

   // DUT ports, the inputs all at known values from time zero
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [CurW-1:0]  req_measured_current = '0;
   logic signed [CurW-1:0]  req_target_current = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [DutyW-1:0]        rsp_duty;
   logic signed [StepW-1:0] rsp_step_out;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CsrIdxW-1:0]      csr_index = '0;
   logic [CsrDataW-1:0]     csr_wdata = '0;

   // Current samples waiting for the driver, and duty/step results still owed
   sample_type    current_q[$];
   duty_step_type duty_step_q[$];

   // Mirror of the loop: register copy plus error, step and accumulator history
   cfg_type ctl;
   longint  err_hist, step_hist, acc_hist;

   // Traffic control, set by the sequence below
   int unsigned send_idle_pct = 0;
   int unsigned rcv_idle_pct  = 0;
   bit          long_hold_req = 1'b0;
   int          hold_left     = 0;

   // Bookkeeping
   bit req_took = 1'b0;
   int samples_queued = 0;
   int samples_sent = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int mismatch_cnt = 0;
   int in_stall_cycles = 0;
   int long_holds = 0;
   int idle_cycles = 0;

   incremental_pi_current_loop u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_measured_current (req_measured_current),
      .req_target_current   (req_target_current),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_duty             (rsp_duty),
      .rsp_step_out         (rsp_step_out),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic cfg_type pack_cfg(int kp, int ki, int maxc, int lim, int lo, int hi);
      cfg_type c;
      c.kp          = kp[GainW-1:0];
      c.ki          = ki[GainW-1:0];
      c.max_current = maxc[LimW-1:0];
      c.step_limit  = lim[LimW-1:0];
      c.min_duty    = lo[DutyW-1:0];
      c.max_duty    = hi[DutyW-1:0];
      return c;
   endfunction

   // One control step of the velocity-form PI loop. Products are floored by
   // the arithmetic shift; the duty window tests the top bound first, so an
   // inverted window still resolves deterministically.
   function automatic duty_step_type loop_update(sample_type s);
      longint        meas, err, prop, integ, step, lim, top, bottom;
      duty_step_type r;
      meas = longint'($signed(s.meas));
      if (meas > longint'(ctl.max_current))
         meas = longint'(ctl.max_current);   // upper clip only
      err   = longint'($signed(s.target)) - meas;
      prop  = (longint'($signed(ctl.kp)) * (err - err_hist)) >>> ShiftW;
      integ = (longint'($signed(ctl.ki)) * err) >>> ShiftW;
      step  = step_hist + prop + integ;
      lim   = longint'(ctl.step_limit);
      if (step > lim)
         step = lim;
      if (step < -lim)
         step = -lim;
      err_hist  = err;
      step_hist = step;
      top    = longint'(ctl.max_duty) << FracW;
      bottom = longint'(ctl.min_duty) << FracW;
      acc_hist += step;
      if (acc_hist > top)
         acc_hist = top;
      else if (acc_hist < bottom)
         acc_hist = bottom;
      r.duty = acc_hist[FracW +: DutyW];
      r.step = step[StepW-1:0];
      return r;
   endfunction

   // Rising edge: everything that crossed a handshake is recorded here.
   always @(posedge clock) begin
      duty_step_type want;
      sample_type    s;
      if (reset) begin
         ctl = pack_cfg(0, 0, MaxCurrentRst, StepLimitRst, MinDutyRst, MaxDutyRst);
         err_hist  = 0;
         step_hist = 0;
         acc_hist  = 0;
         req_took  = 1'b0;
      end else begin
         req_took = req_valid && !req_stall;

         // results first: an item taken on this edge cannot be out yet
         if (rsp_valid && !rsp_stall) begin
            if (duty_step_q.size() == 0) begin
               $error("result with nothing pending: duty %0d step %0d", rsp_duty, rsp_step_out);
               mismatch_cnt++;
            end else begin
               want = duty_step_q.pop_front();
               if (rsp_duty !== want.duty) begin
                  $error("duty: expected %0d, actual %0d", want.duty, rsp_duty);
                  mismatch_cnt++;
               end
               if (rsp_step_out !== want.step) begin
                  $error("step_out: expected %0d, actual %0d", want.step, rsp_step_out);
                  mismatch_cnt++;
               end
               results_checked++;
            end
         end

         if (req_took) begin
            s.meas   = req_measured_current;
            s.target = req_target_current;
            duty_step_q.push_back(loop_update(s));
            samples_sent++;
         end

         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_KP:          ctl.kp          = csr_wdata;
               CSR_KI:          ctl.ki          = csr_wdata;
               CSR_MAX_CURRENT: ctl.max_current = csr_wdata[LimW-1:0];
               CSR_STEP_LIMIT:  ctl.step_limit  = csr_wdata[LimW-1:0];
               CSR_MIN_DUTY:    ctl.min_duty    = csr_wdata[DutyW-1:0];
               CSR_MAX_DUTY:    ctl.max_duty    = csr_wdata[DutyW-1:0];
               default: ;
            endcase
            csr_writes++;
         end

         if (req_stall)
            in_stall_cycles++;

         // watchdog: any handshake counts as progress
         if (req_took || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= StallWatchLimit) begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, duty_step_q.size());
            $display("[incremental_pi_current_loop] ERROR");
            $finish;
         end
      end
   end

   // Sample driver: a new item only once the previous one was taken; a
   // stalled item holds its payload.
   always @(negedge clock) begin
      sample_type s;
      if (!reset && (!req_valid || req_took)) begin
         if (current_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            s = current_q.pop_front();
            req_valid            <= 1'b1;
            req_measured_current <= s.meas;
            req_target_current   <= s.target;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stall, or a long hold-off on request so the
   // pipe fills and pushes back on the input.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left     = LongHoldCycles - 1;
         rsp_stall    <= 1'b1;
         long_holds++;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   function automatic void push_sample(int meas, int target);
      sample_type s;
      s.meas   = meas[CurW-1:0];
      s.target = target[CurW-1:0];
      current_q.push_back(s);
      samples_queued++;
   endfunction

   // Mostly a loop near its operating point (measurement tracking target with
   // noise), some samples above the clip, the rest anything at all.
   function automatic void push_random_sample();
      int unsigned pick;
      int          t, m;
      pick = $urandom_range(99);
      if (pick < 55) begin
         t = int'($urandom_range(16383)) - 8192;
         m = t + int'($urandom_range(1023)) - 512;
      end else if (pick < 70 && ctl.max_current < 15'h7fff) begin
         t = int'($urandom_range(65535)) - 32768;
         m = int'(ctl.max_current) + 1 + int'($urandom_range(32766 - int'(ctl.max_current)));
      end else begin
         t = int'($urandom_range(65535)) - 32768;
         m = int'($urandom_range(65535)) - 32768;
      end
      push_sample(m, t);
   endfunction

   // Tame settings keep the loop regulating; wild ones may invert the window.
   function automatic cfg_type random_cfg(bit tame);
      if (tame)
         return pack_cfg(int'($urandom_range(1023)) - 512, int'($urandom_range(255)) - 128,
                         $urandom_range(16384, 32767), $urandom_range(256, 4096),
                         $urandom_range(200), $urandom_range(1000, 8191));
      return pack_cfg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // Wait until every queued sample went in and every result came back.
   task automatic drain();
      while (samples_sent != samples_queued || duty_step_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CsrDataW-1:0] data);
      int n;
      @(negedge clock);
      n = csr_writes;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      while (csr_writes == n)
         @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Registers change only with the loop empty.
   task automatic apply_settings(cfg_type c);
      drain();
      write_reg(CSR_KP, c.kp);
      write_reg(CSR_KI, c.ki);
      write_reg(CSR_MAX_CURRENT, c.max_current);
      write_reg(CSR_STEP_LIMIT, c.step_limit);
      write_reg(CSR_MIN_DUTY, c.min_duty);
      write_reg(CSR_MAX_DUTY, c.max_duty);
   endtask

   initial begin
      int per_phase;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: default registers, zero gains. First step after reset
      // lifts the accumulator from zero into the duty window.
      push_sample(0, 0);
      push_sample(4096, 8192);
      push_sample(-32768, 32767);
      drain();

      // Moderate gains, low current clip: clipped and negative measurements.
      apply_settings(pack_cfg(256, 64, 8192, 2560, 10, 4190));
      push_sample(32767, -32768);
      push_sample(-32768, -32768);
      push_sample(8192, 8192);
      push_sample(8193, 0);
      push_sample(-4096, 4096);
      push_sample(0, 32767);
      push_sample(32767, 32767);
      push_sample(-32768, 32767);

      // Register extremes: clip at zero, widest step and window.
      apply_settings(pack_cfg(-32768, 32767, 0, 32767, 0, 8191));
      push_sample(32767, -32768);
      push_sample(-32768, 32767);
      push_sample(0, 0);
      push_sample(-1, -1);
      push_sample(1, 0);

      // Zero step limit: step pinned at zero whatever the gains.
      apply_settings(pack_cfg(32767, -32768, 32767, 0, 0, 8191));
      push_sample(100, -100);
      push_sample(-32768, 32767);
      push_sample(32767, -32768);

      // Inverted window: top bound is tested first.
      apply_settings(pack_cfg(4096, 2048, 32767, 32767, 5000, 100));
      push_sample(0, 4096);
      push_sample(0, -4096);
      push_sample(0, 0);
      push_sample(0, 32767);

      // Random part: sender dense / receiver mostly stalled, then swapped, then both
      // flat out with one long receiver hold-off against a full sender.
      per_phase = RandomItems / RandomPhases;
      for (int ph = 0; ph < RandomPhases; ph++) begin
         if (ph == 1)
            apply_settings(pack_cfg(32767, 32767, 32767, 32767, 0, 8191));
         else
            apply_settings(random_cfg(ph % 2 == 0 || ph == 5));
         if (ph < 2) begin
            send_idle_pct = 19;
            rcv_idle_pct  = 86;
         end else if (ph < 4) begin
            send_idle_pct = 86;
            rcv_idle_pct  = 19;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         for (int k = 0; k < per_phase; k++)
            push_random_sample();
         if (ph == RandomPhases - 1)
            long_hold_req = 1'b1;
      end

      drain();
      repeat (TailCycles) @(posedge clock);

      $display("%0d current samples over %0d register writes, %0d duty/step results checked",
               samples_sent, csr_writes, results_checked);
      $display("input held off on %0d cycles, %0d long receiver hold-off(s)",
               in_stall_cycles, long_holds);
      if (mismatch_cnt == 0)
         $display("[incremental_pi_current_loop] OK");
      else
         $display("[incremental_pi_current_loop] ERROR");
      $finish;
   end

endmodule
